[design/ycck_pkg.sv]
// ----------------------------------------------------------------------------
// ycck_pkg: shared types and constants of the YCrCb distance keyer
// Register indexes, mask classes and the bus carried through the search cells.
// ----------------------------------------------------------------------------
package ycck_pkg;

    localparam int KEY_W  = 12;
    localparam int THR_W  = 13;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 13;
    localparam int MASK_W = 8;
    // running threshold value 255*inner + m*span stays below 255*8192
    localparam int TW     = 21;

    typedef enum logic [IDX_W-1:0] {
        REG_KEY_LUMA   = 3'd0,
        REG_KEY_CR     = 3'd1,
        REG_KEY_CB     = 3'd2,
        REG_INNER      = 3'd3,
        REG_OUTER      = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLS_RAMP = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_FULL = 2'd2
    } mask_cls_t;

    typedef struct packed {
        mask_cls_t          cls;
        logic [MASK_W-1:0]  lo;
    } cell_bus_t;

endpackage

[design/ycrcb_distance_chroma_keyer.sv]
// ----------------------------------------------------------------------------
// ycrcb_distance_chroma_keyer: soft chroma key mask from YCrCb distance
// Converts a BGR pixel to YCrCb, measures the distance to the key color and
// maps it to a mask byte through an inner and outer threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: pixel_valid/pixel_ready with blue, green, red. A transfer
//   happens on a rising edge with both high.
//   Mask channel: mask_valid/mask_ready with mask, same rule.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   on the edge; indexes beyond the list are ignored. Write only while idle.
//   Pipeline: 13 register stages from the pixel transfer to mask_valid:
//   five front stages (luma, chroma, squares, sum, scale) and eight
//   search cells, one mask bit each, most significant first.
//   Throughput: one pixel per cycle unless stalled; every stage is a register
//   and each search cell tries one bit with a single 21x21 square and compare.
//   Stall: a stage advances when it is empty or the next one advances, so a
//   stalled receiver fills bubbles before pixel_ready drops; mask holds.
//   Reset: all stages empty, registers return to their reset values.
// ----------------------------------------------------------------------------
module ycrcb_distance_chroma_keyer #(
    parameter int FRAC_BITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    green,
    input  logic [7:0]                    red,
    output logic                          mask_valid,
    input  logic                          mask_ready,
    output logic [ycck_pkg::MASK_W-1:0]   mask,
    input  logic                          cfg_write,
    input  logic [ycck_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ycck_pkg::DATA_W-1:0]   cfg_data
);

    localparam int DW  = (8 + FRAC_BITS > ycck_pkg::KEY_W) ? 8 + FRAC_BITS : ycck_pkg::KEY_W;
    localparam int LW  = 2*DW + 18;
    localparam int NF  = 5;
    localparam int NC  = 8;
    localparam int NS  = NF + NC;

    // configuration registers
    logic [ycck_pkg::KEY_W-1:0]   key_luma_reg, key_cr_reg, key_cb_reg;
    logic [ycck_pkg::THR_W-1:0]   inner_reg, outer_reg, span;
    logic [2*ycck_pkg::THR_W-1:0] inner_sq_reg, outer_sq_reg;

    // stage occupancy and advance
    logic [NS-1:0] v_reg, v_next;
    logic [NS:0]   rdy;

    // search chain buses
    logic [LW-1:0]             lhs_c [0:NC];
    logic [ycck_pkg::TW-1:0]   acc_c [0:NC];
    ycck_pkg::cell_bus_t       bus_c [0:NC];

    // write one register; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_luma_reg <= 12'd4080;
            key_cr_reg   <= 12'd2048;
            key_cb_reg   <= 12'd2048;
            inner_reg    <= 13'd336;
            outer_reg    <= 13'd352;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ycck_pkg::REG_KEY_LUMA: key_luma_reg <= cfg_data[ycck_pkg::KEY_W-1:0];
                ycck_pkg::REG_KEY_CR:   key_cr_reg   <= cfg_data[ycck_pkg::KEY_W-1:0];
                ycck_pkg::REG_KEY_CB:   key_cb_reg   <= cfg_data[ycck_pkg::KEY_W-1:0];
                ycck_pkg::REG_INNER:    inner_reg    <= cfg_data[ycck_pkg::THR_W-1:0];
                ycck_pkg::REG_OUTER:    outer_reg    <= cfg_data[ycck_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // squared thresholds follow the registers in the next cycle
    always_ff @(posedge clk)
    begin
        inner_sq_reg <= (2*ycck_pkg::THR_W)'(inner_reg) * (2*ycck_pkg::THR_W)'(inner_reg);
        outer_sq_reg <= (2*ycck_pkg::THR_W)'(outer_reg) * (2*ycck_pkg::THR_W)'(outer_reg);
    end

    assign span = outer_reg - inner_reg;

    // advance a stage when it is empty or its successor advances
    always_comb
    begin
        rdy[NS] = mask_ready;
        for (int i = NS - 1; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
        for (int i = 0; i < NS; i++)
        begin
            if (rdy[i])
                v_next[i] = (i == 0) ? pixel_valid : v_reg[(i == 0) ? 0 : i - 1];
            else
                v_next[i] = v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign pixel_ready = rdy[0];

    ycck_front #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW),
        .LW        (LW)
    ) u_front (
        .clk             (clk),
        .en              (rdy[NF-1:0]),
        .blue            (blue),
        .green           (green),
        .red             (red),
        .key_luma        (key_luma_reg),
        .key_red_chroma  (key_cr_reg),
        .key_blue_chroma (key_cb_reg),
        .inner_threshold (inner_reg),
        .outer_threshold (outer_reg),
        .inner_sq        (inner_sq_reg),
        .outer_sq        (outer_sq_reg),
        .lhs             (lhs_c[0]),
        .base            (acc_c[0]),
        .bus             (bus_c[0])
    );

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        ycck_cell #(
            .LW  (LW),
            .BIT (NC - 1 - k)
        ) u_cell (
            .clk     (clk),
            .en      (rdy[NF+k]),
            .lhs_in  (lhs_c[k]),
            .acc_in  (acc_c[k]),
            .span    (span),
            .bus_in  (bus_c[k]),
            .lhs_out (lhs_c[k+1]),
            .acc_out (acc_c[k+1]),
            .bus_out (bus_c[k+1])
        );
    end

    assign mask_valid = v_reg[NS-1];

    always_comb
    begin
        case (bus_c[NC].cls)
            ycck_pkg::CLS_FULL: mask = '1;
            ycck_pkg::CLS_ZERO: mask = '0;
            default:            mask = bus_c[NC].lo;
        endcase
    end

    // a transfer in fills the first stage
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> v_reg[0])
        else $error("accepted pixel missing from first stage");

    // a blocked input means the first stage is occupied
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> v_reg[0])
        else $error("input stalled with an empty first stage");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid && !mask_ready |=> mask_valid && $stable(mask))
        else $error("stalled mask changed");

    // the last stage drains when the receiver takes it and the stage before is empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid && mask_ready && !v_reg[NS-2] |=> !mask_valid)
        else $error("mask repeated");

endmodule

[design/ycck_front.sv]
// ----------------------------------------------------------------------------
// ycck_front: color conversion and squared distance
// Five stages: luma, chroma, squared differences, sum, scale and classify.
// ----------------------------------------------------------------------------
module ycck_front #(
    parameter int FRAC_BITS = 4,
    parameter int DW        = 12,
    parameter int LW        = 42
) (
    input  logic                         clk,
    input  logic [4:0]                   en,
    input  logic [7:0]                   blue,
    input  logic [7:0]                   green,
    input  logic [7:0]                   red,
    input  logic [ycck_pkg::KEY_W-1:0]   key_luma,
    input  logic [ycck_pkg::KEY_W-1:0]   key_red_chroma,
    input  logic [ycck_pkg::KEY_W-1:0]   key_blue_chroma,
    input  logic [ycck_pkg::THR_W-1:0]   inner_threshold,
    input  logic [ycck_pkg::THR_W-1:0]   outer_threshold,
    input  logic [2*ycck_pkg::THR_W-1:0] inner_sq,
    input  logic [2*ycck_pkg::THR_W-1:0] outer_sq,
    output logic [LW-1:0]                lhs,
    output logic [ycck_pkg::TW-1:0]      base,
    output ycck_pkg::cell_bus_t          bus
);

    localparam int D2W = 2*DW + 2;

    // stage 1: luma
    logic [21:0] y_sum;
    logic [7:0]  y1_reg, r1_reg, b1_reg;
    // stage 2: chroma
    logic signed [8:0]  dr, db;
    logic signed [24:0] pr, pb;
    logic [7:0]  y2_reg, cr2_reg, cb2_reg;
    // stage 3: squares
    logic [DW-1:0]   sy, scr, scb, ay, acr, acb;
    logic [2*DW-1:0] qy_reg, qr_reg, qb_reg;
    // stage 4: sum
    logic [D2W-1:0]  d2_reg;
    // stage 5
    logic [LW-1:0]             lhs_reg;
    logic [ycck_pkg::TW-1:0]   base_reg;
    ycck_pkg::cell_bus_t       bus_reg;
    ycck_pkg::mask_cls_t       cls;

    function automatic logic [7:0] chroma_clamp(input logic signed [24:0] v);
        logic [7:0] res;
        if (v < 0)
            res = 8'd0;
        else if (v[24:14] > 11'd255)
            res = 8'd255;
        else
            res = v[21:14];
        return res;
    endfunction

    function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a,
                                               input logic [DW-1:0] b);
        logic [DW-1:0] res;
        res = (a > b) ? (a - b) : (b - a);
        return res;
    endfunction

    assign y_sum = 22'(14'd4899 * red) + 22'(14'd9617 * green)
                 + 22'(11'd1868 * blue) + 22'd8192;

    assign dr = $signed({1'b0, r1_reg}) - $signed({1'b0, y1_reg});
    assign db = $signed({1'b0, b1_reg}) - $signed({1'b0, y1_reg});
    assign pr = 25'(dr) * 25'sd11682 + 25'sd2105344;
    assign pb = 25'(db) * 25'sd9241  + 25'sd2105344;

    assign sy  = DW'(y2_reg)  << FRAC_BITS;
    assign scr = DW'(cr2_reg) << FRAC_BITS;
    assign scb = DW'(cb2_reg) << FRAC_BITS;
    assign ay  = abs_diff(sy,  DW'(key_luma));
    assign acr = abs_diff(scr, DW'(key_red_chroma));
    assign acb = abs_diff(scb, DW'(key_blue_chroma));

    always_comb
    begin
        if (D2W'(d2_reg) < D2W'(inner_sq))
            cls = ycck_pkg::CLS_ZERO;
        else if (D2W'(d2_reg) > D2W'(outer_sq))
            cls = ycck_pkg::CLS_FULL;
        else if (outer_threshold <= inner_threshold)
            cls = ycck_pkg::CLS_ZERO;
        else
            cls = ycck_pkg::CLS_RAMP;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y1_reg <= y_sum[21:14];
            r1_reg <= red;
            b1_reg <= blue;
        end
        if (en[1])
        begin
            y2_reg  <= y1_reg;
            cr2_reg <= chroma_clamp(pr);
            cb2_reg <= chroma_clamp(pb);
        end
        if (en[2])
        begin
            qy_reg <= ay * ay;
            qr_reg <= acr * acr;
            qb_reg <= acb * acb;
        end
        if (en[3])
            d2_reg <= D2W'(qy_reg) + D2W'(qr_reg) + D2W'(qb_reg);
        if (en[4])
        begin
            lhs_reg    <= LW'(d2_reg) * LW'(17'd65025);
            base_reg   <= ycck_pkg::TW'(inner_threshold) * ycck_pkg::TW'(9'd255);
            bus_reg.cls <= cls;
            bus_reg.lo  <= '0;
        end
    end

    assign lhs  = lhs_reg;
    assign base = base_reg;
    assign bus  = bus_reg;

endmodule

[design/ycck_cell.sv]
// ----------------------------------------------------------------------------
// ycck_cell: one bit of the mask search
// Try the bit; keep it when the squared threshold still fits under 255^2*d^2.
// ----------------------------------------------------------------------------
module ycck_cell #(
    parameter int LW  = 42,
    parameter int BIT = 7
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [LW-1:0]               lhs_in,
    input  logic [ycck_pkg::TW-1:0]     acc_in,
    input  logic [ycck_pkg::THR_W-1:0]  span,
    input  ycck_pkg::cell_bus_t         bus_in,
    output logic [LW-1:0]               lhs_out,
    output logic [ycck_pkg::TW-1:0]     acc_out,
    output ycck_pkg::cell_bus_t         bus_out
);

    localparam int SQW = 2*ycck_pkg::TW;
    localparam int CW  = (LW > SQW) ? LW : SQW;

    logic [ycck_pkg::TW-1:0] t;
    logic [SQW-1:0]          sq;
    logic                    take;
    logic [LW-1:0]           lhs_reg;
    logic [ycck_pkg::TW-1:0] acc_reg;
    ycck_pkg::cell_bus_t     bus_reg;

    assign t    = acc_in + (ycck_pkg::TW'(span) << BIT);
    assign sq   = SQW'(t) * SQW'(t);
    assign take = (CW'(lhs_in) >= CW'(sq));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs_reg     <= lhs_in;
            bus_reg.cls <= bus_in.cls;
            if (take)
            begin
                acc_reg         <= t;
                bus_reg.lo      <= bus_in.lo | ycck_pkg::MASK_W'(1 << BIT);
            end
            else
            begin
                acc_reg    <= acc_in;
                bus_reg.lo <= bus_in.lo;
            end
        end
    end

    assign lhs_out = lhs_reg;
    assign acc_out = acc_reg;
    assign bus_out = bus_reg;

endmodule

[tb/sv/tb_ycrcb_distance_chroma_keyer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ycrcb_distance_chroma_keyer: self-checking bench of the chroma keyer
// Streams BGR pixels through the keyer, predicts each mask byte from an
// independent YCrCb distance model and compares every mask transfer in order.
// ----------------------------------------------------------------------------
module tb_ycrcb_distance_chroma_keyer;

    localparam int FRAC     = 4;
    localparam int LATENCY  = 13;
    localparam int STALL_LIM = 2000;

    logic                           clk;
    logic                           rst_n;
    logic                           pixel_valid;
    logic                           pixel_ready;
    logic [7:0]                     blue;
    logic [7:0]                     green;
    logic [7:0]                     red;
    logic                           mask_valid;
    logic                           mask_ready;
    logic [ycck_pkg::MASK_W-1:0]    mask;
    logic                           cfg_write;
    logic [ycck_pkg::IDX_W-1:0]     cfg_index;
    logic [ycck_pkg::DATA_W-1:0]    cfg_data;

    // shadow copy of the key and threshold registers
    logic [ycck_pkg::KEY_W-1:0]     sh_key_y;
    logic [ycck_pkg::KEY_W-1:0]     sh_key_cr;
    logic [ycck_pkg::KEY_W-1:0]     sh_key_cb;
    logic [ycck_pkg::THR_W-1:0]     sh_inner;
    logic [ycck_pkg::THR_W-1:0]     sh_outer;

    logic [ycck_pkg::MASK_W-1:0]    pending_masks[$];
    int                             n_errors;
    bit                             tx_idle_en;
    bit                             rx_idle_en;
    int                             quiet_cycles;

    ycrcb_distance_chroma_keyer #(.FRAC_BITS(FRAC)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .mask_valid  (mask_valid),
        .mask_ready  (mask_ready),
        .mask        (mask),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Round a chroma term half up and clamp to a byte.
    function automatic longint chroma_byte(longint diff, longint coef);
        longint v;
        v = diff * coef + (longint'(128) << 14) + 8192;
        if (v < 0)
            return 0;
        v = v >>> 14;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic longint abs_sq(longint a, longint b);
        longint d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    // Compute the expected mask byte for one pixel under the shadow registers.
    function automatic logic [ycck_pkg::MASK_W-1:0] keyed_mask(logic [7:0] b8,
                                                               logic [7:0] g8,
                                                               logic [7:0] r8);
        longint y, cr, cb, d2, inr, otr, lhs, span, lo, hi, mid, t;
        y = (4899 * longint'(r8) + 9617 * longint'(g8) + 1868 * longint'(b8) + 8192) >>> 14;
        if (y > 255)
            y = 255;
        cr = chroma_byte(longint'(r8) - y, 11682);
        cb = chroma_byte(longint'(b8) - y, 9241);
        d2 = abs_sq(y << FRAC, longint'(sh_key_y))
           + abs_sq(cr << FRAC, longint'(sh_key_cr))
           + abs_sq(cb << FRAC, longint'(sh_key_cb));
        inr = longint'(sh_inner);
        otr = longint'(sh_outer);
        if (d2 < inr * inr)
            return 8'd0;
        if (d2 > otr * otr)
            return 8'd255;
        if (otr <= inr)
            return 8'd0;
        // search the largest ramp step whose threshold square still fits
        lhs = 65025 * d2;
        span = otr - inr;
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            t = 255 * inr + mid * span;
            if (lhs >= t * t)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[7:0];
    endfunction

    // Write one register while idle; mirror it into the shadow copy.
    task automatic write_reg(ycck_pkg::reg_idx_t idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[ycck_pkg::DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            ycck_pkg::REG_KEY_LUMA: sh_key_y  = value[ycck_pkg::KEY_W-1:0];
            ycck_pkg::REG_KEY_CR:   sh_key_cr = value[ycck_pkg::KEY_W-1:0];
            ycck_pkg::REG_KEY_CB:   sh_key_cb = value[ycck_pkg::KEY_W-1:0];
            ycck_pkg::REG_INNER:    sh_inner  = value[ycck_pkg::THR_W-1:0];
            ycck_pkg::REG_OUTER:    sh_outer  = value[ycck_pkg::THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_key(int ky, int kcr, int kcb, int inr, int otr);
        write_reg(ycck_pkg::REG_KEY_LUMA, ky);
        write_reg(ycck_pkg::REG_KEY_CR, kcr);
        write_reg(ycck_pkg::REG_KEY_CB, kcb);
        write_reg(ycck_pkg::REG_INNER, inr);
        write_reg(ycck_pkg::REG_OUTER, otr);
    endtask

    // Send one pixel; the prediction is queued at the transfer edge.
    // Valid stays high after the transfer until the next pixel, a gap or drain.
    task automatic send_pixel(logic [7:0] b8, logic [7:0] g8, logic [7:0] r8);
        int gap;
        if (tx_idle_en && ($urandom_range(0, 3) == 0))
        begin
            gap = $urandom_range(1, 6);
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        blue        <= b8;
        green       <= g8;
        red         <= r8;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        pending_masks.push_back(keyed_mask(b8, g8, r8));
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endtask

    // Wait until every mask has come back, then let the pipeline drain.
    task automatic drain;
        pixel_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Receiver: drop ready in random bursts, check each mask transfer.
    always
    begin
        @(negedge clk);
        if (rx_idle_en && ($urandom_range(0, 3) == 0))
        begin
            mask_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        mask_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && mask_valid && mask_ready)
        begin
            if (pending_masks.size() == 0)
            begin
                $error("mask: unexpected transfer, actual %0d", mask);
                n_errors++;
            end
            else
            begin
                if (mask !== pending_masks[0])
                begin
                    $error("mask: expected %0d, actual %0d", pending_masks[0], mask);
                    n_errors++;
                end
                void'(pending_masks.pop_front());
            end
        end
    end

    // Watchdog: count cycles with work pending but no transfer or config write.
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (mask_valid && mask_ready) || cfg_write
            || (pending_masks.size() == 0 && !pixel_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset values, channel extremes, white and black pixels.
    task automatic test_reset_key;
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd254, 8'd250, 8'd252);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        drain();
    endtask

    // Green key with a wide ramp, so the middle values show up.
    task automatic test_green_ramp;
        set_key(145 * 16, 34 * 16, 54 * 16, 200, 2600);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd40, 8'd200, 8'd40);
        send_random(4);
        drain();
    endtask

    // Equal thresholds, a pixel lying exactly at the key, outer below inner.
    task automatic test_threshold_edges;
        // key at black's YCrCb: (0,128,128), distance exactly 0 and at outer
        set_key(0, 128 * 16, 128 * 16, 0, 0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd1, 8'd1);
        drain();
        write_reg(ycck_pkg::REG_OUTER, 16);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();
        set_key(4095, 4095, 4095, 7071, 100);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_random(2);
        drain();
    endtask

    // Random pixels across several key settings, extremes among them.
    task automatic test_random_sweep;
        int phase;
        int inr;
        for (phase = 0; phase < 8; phase++)
        begin
            inr = $urandom_range(0, 3000);
            case (phase)
                0: set_key(0, 0, 0, 0, 7071);
                1: set_key(4095, 4095, 4095, 0, 7071);
                2: set_key(2048, 2048, 2048, 7071, 7071);
                3: set_key(8191, 8191, 8191, 8191, 8191);
                default: set_key($urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 4095), inr,
                                 inr + $urandom_range(0, 4000));
            endcase
            // out-of-range index must be ignored
            write_reg(ycck_pkg::reg_idx_t'(3'd7), $urandom_range(0, 8191));
            if (phase == 7)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            send_random(78);
            drain();
        end
    endtask

    initial
    begin
        n_errors     = 0;
        quiet_cycles = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        blue         = '0;
        green        = '0;
        red          = '0;
        mask_ready   = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sh_key_y     = 12'd4080;
        sh_key_cr    = 12'd2048;
        sh_key_cb    = 12'd2048;
        sh_inner     = 13'd336;
        sh_outer     = 13'd352;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_key();
        test_green_ramp();
        test_threshold_edges();
        test_random_sweep();

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
